// File: hdl/rcw_pkg.sv
// Shared types and constants for the rainbow color wheel.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package rcw_pkg;

    // Width of the color channels and their full-scale value.
    localparam int unsigned CHAN_W = 8;
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'hFF;

    // Number of quotient bits produced by the ramp divider.
    localparam int unsigned QUOT_W = CHAN_W;

    // Configuration port.
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 32'd6000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD    = 1'b0,
        CFG_LOW_POWER = 1'b1
    } t_cfg_index;

    // Region of the wheel the position falls into. Three-phase mode only
    // uses the first three codes.
    typedef enum logic [2:0] {
        RGN_0 = 3'd0,
        RGN_1 = 3'd1,
        RGN_2 = 3'd2,
        RGN_3 = 3'd3,
        RGN_4 = 3'd4,
        RGN_5 = 3'd5
    } t_region;

    // Per-item control that rides along with the arithmetic stages.
    typedef struct packed {
        logic    beyond;   // position above the period, color forced black
        logic    sat;      // offset reached the step, ramp saturates
        t_region region;
    } t_side;

endpackage

`default_nettype wire

// File: hdl/rcw_front.sv
// Front stages of the color wheel: input register, period check, region
// search, offset and the offset*255 product. Uses rcw_pkg.
`default_nettype none

module rcw_front #(
    parameter int unsigned POS_WIDTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_ce,
    input  wire                       i_valid,
    input  wire  [POS_WIDTH-1:0]      i_pos,
    input  wire  [POS_WIDTH-1:0]      i_period,
    input  wire  [POS_WIDTH-1:0]      i_step,
    input  wire                       i_mode,
    output logic                      o_valid,
    output rcw_pkg::t_side            o_side,
    output logic [POS_WIDTH+7:0]      o_prod
);

    localparam int unsigned MW = POS_WIDTH + 3;
    localparam int unsigned PW = POS_WIDTH + 8;

    logic                 r_a_valid;
    logic [POS_WIDTH-1:0] r_a_pos;
    logic                 r_b_valid;
    logic [POS_WIDTH-1:0] r_b_pos;
    logic                 r_b_beyond;
    logic                 r_c_valid;
    logic [POS_WIDTH-1:0] r_c_pos;
    logic [POS_WIDTH-1:0] r_c_base;
    rcw_pkg::t_side       r_c_side;
    logic                 r_d_valid;
    logic [POS_WIDTH-1:0] r_d_offset;
    rcw_pkg::t_side       r_d_side;
    logic                 r_e_valid;
    logic [PW-1:0]        r_e_prod;
    rcw_pkg::t_side       r_e_side;

    logic [MW-1:0]        m1, m2, m3, m4, m5, pos_ext;
    logic [5:1]           ge;
    rcw_pkg::t_region     n_region;
    logic [POS_WIDTH-1:0] n_base;
    rcw_pkg::t_side       n_c_side;
    rcw_pkg::t_side       n_e_side;
    logic [PW-1:0]        off_ext;

    // Multiples of the step; the region is the number of multiples the
    // position has reached, capped by the region count of the mode.
    always_comb begin
        m1      = MW'(i_step);
        m2      = m1 << 1;
        m3      = m1 + m2;
        m4      = m1 << 2;
        m5      = m1 + m4;
        pos_ext = MW'(r_b_pos);
        ge[1]   = pos_ext >= m1;
        ge[2]   = pos_ext >= m2;
        ge[3]   = pos_ext >= m3;
        ge[4]   = pos_ext >= m4;
        ge[5]   = pos_ext >= m5;

        if (i_mode) begin
            if (ge[2])      n_region = rcw_pkg::RGN_2;
            else if (ge[1]) n_region = rcw_pkg::RGN_1;
            else            n_region = rcw_pkg::RGN_0;
        end else begin
            if (ge[5])      n_region = rcw_pkg::RGN_5;
            else if (ge[4]) n_region = rcw_pkg::RGN_4;
            else if (ge[3]) n_region = rcw_pkg::RGN_3;
            else if (ge[2]) n_region = rcw_pkg::RGN_2;
            else if (ge[1]) n_region = rcw_pkg::RGN_1;
            else            n_region = rcw_pkg::RGN_0;
        end

        // The selected multiple never exceeds the position, so it fits.
        case (n_region)
            rcw_pkg::RGN_1: n_base = m1[POS_WIDTH-1:0];
            rcw_pkg::RGN_2: n_base = m2[POS_WIDTH-1:0];
            rcw_pkg::RGN_3: n_base = m3[POS_WIDTH-1:0];
            rcw_pkg::RGN_4: n_base = m4[POS_WIDTH-1:0];
            rcw_pkg::RGN_5: n_base = m5[POS_WIDTH-1:0];
            default:        n_base = '0;
        endcase

        n_c_side.beyond = r_b_beyond;
        n_c_side.sat    = 1'b0;
        n_c_side.region = n_region;

        // offset*255/step reaches 255 exactly when offset reaches step.
        n_e_side        = r_d_side;
        n_e_side.sat    = r_d_offset >= i_step;
        off_ext         = PW'(r_d_offset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_ce) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_pos    <= i_pos;
            r_b_pos    <= r_a_pos;
            r_b_beyond <= r_a_pos > i_period;
            r_c_pos    <= r_b_pos;
            r_c_base   <= n_base;
            r_c_side   <= n_c_side;
            r_d_offset <= r_c_pos - r_c_base;
            r_d_side   <= r_c_side;
            r_e_prod   <= (off_ext << rcw_pkg::CHAN_W) - off_ext;
            r_e_side   <= n_e_side;
        end
    end

    assign o_valid = r_e_valid;
    assign o_side  = r_e_side;
    assign o_prod  = r_e_prod;

endmodule

`default_nettype wire

// File: hdl/rcw_div.sv
// Pipelined restoring divider for the ramp value: one quotient bit per
// stage, offset*255 divided by the step. Uses rcw_pkg.
`default_nettype none

module rcw_div #(
    parameter int unsigned POS_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_ce,
    input  wire                          i_valid,
    input  rcw_pkg::t_side               i_side,
    input  wire  [POS_WIDTH+7:0]         i_prod,
    input  wire  [POS_WIDTH-1:0]         i_step,
    output logic                         o_valid,
    output rcw_pkg::t_side               o_side,
    output logic [rcw_pkg::QUOT_W-1:0]   o_quot
);

    localparam int unsigned RW = POS_WIDTH + 8;
    localparam int unsigned NS = rcw_pkg::QUOT_W;

    logic                       r_v    [NS];
    rcw_pkg::t_side             r_sd   [NS];
    logic [rcw_pkg::QUOT_W-1:0] r_q    [NS];
    logic [RW-1:0]              r_rem  [NS-1];

    // Unsaturated items have a quotient below 255, so the remainder enters
    // below 256*step and eight stages cover it.
    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int unsigned BIT = NS - 1 - k;

        logic                       v_in;
        rcw_pkg::t_side             sd_in;
        logic [rcw_pkg::QUOT_W-1:0] q_in;
        logic [rcw_pkg::QUOT_W-1:0] q_out;
        logic [RW-1:0]              rem_in;
        logic [RW:0]                trial;
        logic                       take;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign sd_in  = i_side;
            assign q_in   = '0;
            assign rem_in = i_prod;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign sd_in  = r_sd[k-1];
            assign q_in   = r_q[k-1];
            assign rem_in = r_rem[k-1];
        end

        assign trial = {1'b0, rem_in} - ((RW + 1)'(i_step) << BIT);
        assign take  = !trial[RW];

        always_comb begin
            q_out      = q_in;
            q_out[BIT] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_sd[k] <= sd_in;
                r_q[k]  <= q_out;
            end
        end

        if (k < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k] <= take ? trial[RW-1:0] : rem_in;
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_side  = r_sd[NS-1];
    assign o_quot  = r_q[NS-1];

endmodule

`default_nettype wire

// File: hdl/rcw_map.sv
// Color mapping stage: turns region, ramp and mode into the three channel
// values and the beyond-period flag. Uses rcw_pkg.
`default_nettype none

module rcw_map (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_ce,
    input  wire                          i_valid,
    input  rcw_pkg::t_side               i_side,
    input  wire  [rcw_pkg::QUOT_W-1:0]   i_quot,
    input  wire                          i_mode,
    output logic                         o_valid,
    output logic [rcw_pkg::CHAN_W-1:0]   o_red,
    output logic [rcw_pkg::CHAN_W-1:0]   o_green,
    output logic [rcw_pkg::CHAN_W-1:0]   o_blue,
    output logic                         o_beyond
);

    logic                        r_valid;
    logic [rcw_pkg::CHAN_W-1:0]  r_red, r_green, r_blue;
    logic                        r_beyond;
    logic [rcw_pkg::CHAN_W-1:0]  up, dn;
    logic [rcw_pkg::CHAN_W-1:0]  n_red, n_green, n_blue;

    always_comb begin
        up      = i_side.sat ? rcw_pkg::FULL_SCALE : i_quot;
        dn      = rcw_pkg::FULL_SCALE - up;
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        if (i_side.beyond) begin
            n_red   = '0;
        end else if (i_mode) begin
            // Three-phase cross-fade, no channel held full.
            case (i_side.region)
                rcw_pkg::RGN_0: begin
                    n_red   = dn;
                    n_green = up;
                end
                rcw_pkg::RGN_1: begin
                    n_green = dn;
                    n_blue  = up;
                end
                default: begin
                    n_red   = up;
                    n_blue  = dn;
                end
            endcase
        end else begin
            case (i_side.region)
                rcw_pkg::RGN_0: begin
                    n_red   = rcw_pkg::FULL_SCALE;
                    n_green = up;
                end
                rcw_pkg::RGN_1: begin
                    n_red   = dn;
                    n_green = rcw_pkg::FULL_SCALE;
                end
                rcw_pkg::RGN_2: begin
                    n_green = rcw_pkg::FULL_SCALE;
                    n_blue  = up;
                end
                rcw_pkg::RGN_3: begin
                    n_green = dn;
                    n_blue  = rcw_pkg::FULL_SCALE;
                end
                rcw_pkg::RGN_4: begin
                    n_red   = up;
                    n_blue  = rcw_pkg::FULL_SCALE;
                end
                default: begin
                    n_red   = rcw_pkg::FULL_SCALE;
                    n_blue  = dn;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_beyond <= i_side.beyond;
        end
    end

    assign o_valid  = r_valid;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_beyond = r_beyond;

endmodule

`default_nettype wire

// File: hdl/rainbow_color_wheel.sv
// Top level of the rainbow color wheel: configuration registers, step
// computation, output register with skid stage. Uses rcw_pkg, rcw_front,
// rcw_div and rcw_map.
`default_nettype none

// Maps a position within the configured period to a rainbow RGB color, one
// position per clock cycle while the skid entry is empty. The depth of the
// pipeline is set by the eight-stage restoring divider that forms the ramp
// value offset*255/step, plus five front stages, the color stage and the
// output register. Input tdata carries the position
// (only the low POS_WIDTH bits count); output tdata carries red, green, blue
// from the low byte up, and tuser bit 0 flags a position above the period,
// which gives black. The step (period/6, or period/3 in low-power mode) is
// recomputed in the cycle after a configuration write. The output register
// and a one-entry skid stage let the pipeline keep accepting while a result
// waits; input tready drops only once the skid entry is occupied.
module rainbow_color_wheel #(
    parameter int unsigned POS_WIDTH = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Position stream.
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [31:0]                       i_s_axis_tdata,   // [31:0] position
    // Color stream.
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,   // [7:0] red, [15:8] green,
                                                                // [23:16] blue
    output logic [0:0]                        o_m_axis_tuser,   // [0] beyond_period
    // Configuration writes.
    input  wire                               i_cfg_we,
    input  wire  [rcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [rcw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned PW = POS_WIDTH + 8;
    localparam int unsigned CW = rcw_pkg::CHAN_W;
    // Reciprocal of 3 for an exact multiply-and-shift over POS_WIDTH bits.
    localparam logic [POS_WIDTH-1:0] RECIP3 =
        POS_WIDTH'(((64'd1 << (POS_WIDTH + 1)) + 64'd2) / 64'd3);

    logic [rcw_pkg::CFG_DATA_W-1:0] r_period;
    logic                           r_mode;
    logic [POS_WIDTH-1:0]           r_step;
    logic [POS_WIDTH-1:0]           per, div_in, n_step;
    logic [2*POS_WIDTH-1:0]         step_prod;
    logic [POS_WIDTH-2:0]           step_q;

    logic                           ce;
    logic                           f_valid;
    rcw_pkg::t_side                 f_side;
    logic [PW-1:0]                  f_prod;
    logic                           d_valid;
    rcw_pkg::t_side                 d_side;
    logic [rcw_pkg::QUOT_W-1:0]     d_quot;
    logic                           p_valid;
    logic [CW-1:0]                  p_red, p_green, p_blue;
    logic                           p_beyond;

    logic                           r_out_valid, n_out_valid;
    logic [3*CW-1:0]                r_out_data, n_out_data;
    logic                           r_out_user, n_out_user;
    logic                           r_skid_valid, n_skid_valid;
    logic [3*CW-1:0]                r_skid_data;
    logic                           r_skid_user;
    logic                           load_out, load_skid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= rcw_pkg::PERIOD_RESET;
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (rcw_pkg::t_cfg_index'(i_cfg_index))
                rcw_pkg::CFG_PERIOD:    r_period <= i_cfg_data;
                rcw_pkg::CFG_LOW_POWER: r_mode   <= i_cfg_data[0];
                default:                r_mode   <= r_mode;
            endcase
        end
    end

    // step = period/3 or (period/2)/3 = period/6, never less than one.
    always_comb begin
        per       = r_period[POS_WIDTH-1:0];
        div_in    = r_mode ? per : (per >> 1);
        step_prod = (2 * POS_WIDTH)'(div_in) * (2 * POS_WIDTH)'(RECIP3);
        step_q    = step_prod[2*POS_WIDTH-1:POS_WIDTH+1];
        n_step    = (step_q == '0) ? POS_WIDTH'(1) : {1'b0, step_q};
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
    end

    // The whole pipeline advances together unless the skid entry is full.
    assign ce              = !r_skid_valid;
    assign o_s_axis_tready = ce;

    rcw_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (i_s_axis_tvalid),
        .i_pos    (i_s_axis_tdata[POS_WIDTH-1:0]),
        .i_period (per),
        .i_step   (r_step),
        .i_mode   (r_mode),
        .o_valid  (f_valid),
        .o_side   (f_side),
        .o_prod   (f_prod)
    );

    rcw_div #(
        .POS_WIDTH (POS_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_prod  (f_prod),
        .i_step  (r_step),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_quot  (d_quot)
    );

    rcw_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (d_valid),
        .i_side   (d_side),
        .i_quot   (d_quot),
        .i_mode   (r_mode),
        .o_valid  (p_valid),
        .o_red    (p_red),
        .o_green  (p_green),
        .o_blue   (p_blue),
        .o_beyond (p_beyond)
    );

    // Output register and skid entry. While the skid entry is empty the
    // item leaving the pipeline goes to the output register if that is free
    // or being taken, and into the skid entry otherwise.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                n_out_data   = r_skid_data;
                n_out_user   = r_skid_user;
                n_skid_valid = 1'b0;
                load_out     = 1'b1;
            end
        end else if (!r_out_valid || i_m_axis_tready) begin
            n_out_valid = p_valid;
            n_out_data  = {p_blue, p_green, p_red};
            n_out_user  = p_beyond;
            load_out    = 1'b1;
        end else if (p_valid) begin
            n_skid_valid = 1'b1;
            load_skid    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
        if (load_skid) begin
            r_skid_data <= {p_blue, p_green, p_red};
            r_skid_user <= p_beyond;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;

`ifndef NO_ASSERTIONS
    // The skid entry only fills behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output is empty");

    // A position above the period always comes out black.
    a_beyond_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("beyond-period result carries a color");

    // A parked item stays parked, unchanged, until the output moves.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_axis_tready) |=>
            (r_skid_valid && $stable(r_skid_data) && $stable(r_skid_user)))
        else $error("skid entry changed while the output was stalled");
`endif

endmodule

`default_nettype wire

// File: bench/rainbow_color_wheel_tb.sv
// Self-checking testbench for the rainbow color wheel (rainbow_color_wheel).
// Depends on rcw_pkg and the block's RTL. Colors are predicted in the bench and
// checked against every output transaction.
`timescale 1ns / 100ps

module rainbow_color_wheel_tb;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned PHASE_ITEMS   = 225;
    localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       beyond;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    typedef struct packed {
        logic [31:0] position;
        t_color      color;
    } t_wheel_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;     // [31:0] position
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;     // [7:0] red, [15:8] green, [23:16] blue
    logic [0:0]  o_m_axis_tuser;     // [0] beyond_period
    logic        i_cfg_we;
    rcw_pkg::t_cfg_index i_cfg_index;
    logic [rcw_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Copy of the configuration as the block should hold it.
    logic [31:0] cur_period;
    logic        cur_low_power;

    t_wheel_entry pending_colors[$];
    bit           quiet;
    int unsigned  cycle_count;
    int unsigned  failures;
    int unsigned  positions_sent;
    int unsigned  colors_checked;
    int unsigned  black_colors;
    int unsigned  wheel_settings;

    rainbow_color_wheel dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Color that the wheel should show for one position under the current setting.
    function automatic t_color wheel_color(input logic [31:0] pos);
        t_color      c;
        logic [63:0] pos_w;
        logic [63:0] num_regions;
        logic [63:0] step;
        logic [63:0] region;
        logic [63:0] ramp;
        logic [7:0]  up;
        logic [7:0]  dn;
        c = '0;
        pos_w = {32'd0, pos};
        if (pos > cur_period) begin
            c.beyond = 1'b1;
        end else begin
            num_regions = cur_low_power ? 64'd3 : 64'd6;
            step = {32'd0, cur_period} / num_regions;
            if (step == 0) begin
                step = 64'd1;
            end
            region = pos_w / step;
            if (region > num_regions - 1) begin
                region = num_regions - 1;
            end
            // The last region may be longer than a step, so the ramp can overshoot.
            ramp = ((pos_w - region * step) * 64'd255) / step;
            up = (ramp > 64'd255) ? rcw_pkg::FULL_SCALE : ramp[7:0];
            dn = rcw_pkg::FULL_SCALE - up;
            if (cur_low_power) begin
                case (rcw_pkg::t_region'(region[2:0]))
                    rcw_pkg::RGN_0: begin
                        c.red = dn; c.green = up; c.blue = 8'd0;
                    end
                    rcw_pkg::RGN_1: begin
                        c.red = 8'd0; c.green = dn; c.blue = up;
                    end
                    default: begin
                        c.red = up; c.green = 8'd0; c.blue = dn;
                    end
                endcase
            end else begin
                case (rcw_pkg::t_region'(region[2:0]))
                    rcw_pkg::RGN_0: begin
                        c.red = rcw_pkg::FULL_SCALE; c.green = up; c.blue = 8'd0;
                    end
                    rcw_pkg::RGN_1: begin
                        c.red = dn; c.green = rcw_pkg::FULL_SCALE; c.blue = 8'd0;
                    end
                    rcw_pkg::RGN_2: begin
                        c.red = 8'd0; c.green = rcw_pkg::FULL_SCALE; c.blue = up;
                    end
                    rcw_pkg::RGN_3: begin
                        c.red = 8'd0; c.green = dn; c.blue = rcw_pkg::FULL_SCALE;
                    end
                    rcw_pkg::RGN_4: begin
                        c.red = up; c.green = 8'd0; c.blue = rcw_pkg::FULL_SCALE;
                    end
                    default: begin
                        c.red = rcw_pkg::FULL_SCALE; c.green = 8'd0; c.blue = dn;
                    end
                endcase
            end
        end
        return c;
    endfunction

    // Mostly positions inside the period, with region edges, overflow and raw noise.
    function automatic logic [31:0] pick_position();
        int unsigned kind;
        logic [63:0] step;
        logic [63:0] cand;
        int unsigned num_regions;
        kind = $urandom_range(0, 9);
        num_regions = cur_low_power ? 3 : 6;
        if (kind == 0) begin
            return $urandom;
        end else if (kind == 1 && cur_period != POS_MAX) begin
            return $urandom_range(POS_MAX, cur_period + 32'd1);
        end else if (kind <= 4) begin
            step = {32'd0, cur_period} / num_regions;
            if (step == 0) begin
                step = 64'd1;
            end
            cand = step * $urandom_range(0, num_regions) + $urandom_range(0, 4);
            cand = (cand >= 2) ? cand - 2 : 64'd0;
            if (cand > {32'd0, cur_period}) begin
                cand = {32'd0, cur_period};
            end
            return cand[31:0];
        end
        return $urandom_range(cur_period, 0);
    endfunction

    task automatic send_position(input logic [31:0] pos);
        t_wheel_entry entry;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 19)) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        entry.position = pos;
        entry.color    = wheel_color(pos);
        pending_colors.push_back(entry);
        positions_sent++;
    endtask

    task automatic drain_colors();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_wheel(input logic [31:0] per, input logic low_power);
        drain_colors();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rcw_pkg::CFG_PERIOD;
        i_cfg_data  <= per;
        @(negedge i_clk);
        i_cfg_index <= rcw_pkg::CFG_LOW_POWER;
        i_cfg_data  <= {31'd0, low_power};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_period    = per;
        cur_low_power = low_power;
        wheel_settings++;
    endtask

    // Reset setting: six regions of 1000, every region edge with both sides of some, and overflow.
    task automatic test_reset_wheel();
        logic [31:0] spots[13];
        spots = '{32'd0, 32'd500, 32'd1000, 32'd1999, 32'd2000, 32'd3000, 32'd4000,
                  32'd4999, 32'd5000, 32'd5999, 32'd6000, 32'd6001, POS_MAX};
        foreach (spots[k]) send_position(spots[k]);
    endtask

    // Three-phase with a period that leaves a long last region where ramps saturate.
    task automatic test_cross_fade_long_tail();
        logic [31:0] spots[7];
        spots = '{32'd0, 32'd2001, 32'd4001, 32'd4002, 32'd6004, 32'd6005, 32'd6006};
        set_wheel(32'd6005, 1'b1);
        foreach (spots[k]) send_position(spots[k]);
    endtask

    // A period shorter than the region count forces a step of one.
    task automatic test_tiny_period();
        set_wheel(32'd4, 1'b0);
        for (int p = 0; p < 6; p += 1) begin
            send_position(32'(p));
        end
    endtask

    task automatic test_random_wheels();
        logic [31:0] per;
        for (int ph = 0; ph < 8; ph += 1) begin
            case (ph)
                0, 1:    per = 32'd6;
                2, 3:    per = POS_MAX;
                4, 7:    per = $urandom_range(200, 6);
                default: per = $urandom_range(POS_MAX, 6);
            endcase
            set_wheel(per, ph[0]);
            for (int n = 0; n < PHASE_ITEMS; n += 1) begin
                // Once per phase, hold off until the pipeline is empty.
                if (n == PHASE_ITEMS / 2) begin
                    drain_colors();
                end
                send_position(pick_position());
            end
        end
    endtask

    task automatic test_full_rate();
        set_wheel($urandom_range(POS_MAX, 6), $urandom_range(0, 1));
        quiet = 1'b1;
        for (int n = 0; n < 200; n += 1) send_position(pick_position());
    endtask

    // Output side: ready runs and stall bursts, always ready in the quiet part.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : color_check
        t_wheel_entry want;
        t_color       got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.red    = o_m_axis_tdata[7:0];
            got.green  = o_m_axis_tdata[15:8];
            got.blue   = o_m_axis_tdata[23:16];
            got.beyond = o_m_axis_tuser[0];
            if (pending_colors.size() == 0) begin
                failures++;
                $display("%0t: unexpected color transaction r=%h g=%h b=%h beyond=%b",
                         $time, got.red, got.green, got.blue, got.beyond);
            end else begin
                want = pending_colors.pop_front();
                colors_checked++;
                if (want.color.beyond) black_colors++;
                if (got.red !== want.color.red || got.green !== want.color.green ||
                    got.blue !== want.color.blue || got.beyond !== want.color.beyond) begin
                    failures++;
                    $display({"%0t: position %h expected r=%h g=%h b=%h beyond=%b,",
                              " got r=%h g=%h b=%h beyond=%b"},
                             $time, want.position, want.color.red, want.color.green,
                             want.color.blue, want.color.beyond,
                             got.red, got.green, got.blue, got.beyond);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d colors outstanding",
                     $time, cycle_count, pending_colors.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        cycle_count     = 0;
        failures        = 0;
        positions_sent  = 0;
        colors_checked  = 0;
        black_colors    = 0;
        wheel_settings  = 1;
        quiet           = 1'b0;
        cur_period      = rcw_pkg::PERIOD_RESET;
        cur_low_power   = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = rcw_pkg::CFG_PERIOD;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_wheel();
        test_cross_fade_long_tail();
        test_tiny_period();
        test_random_wheels();
        test_full_rate();
        drain_colors();

        if (pending_colors.size() != 0) failures++;
        $display("Run covered %0d positions over %0d wheel settings in both modes;",
                 positions_sent, wheel_settings);
        $display("%0d colors checked, %0d of them black past the period.",
                 colors_checked, black_colors);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
